/* sv/lrrp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lrrp_pkg
// Shared types, token codes and register indexes of the location report parser.
// ----------------------------------------------------------------------------
package lrrp_pkg;

	// token codes
	localparam logic [7:0] TOK_LEN       = 8'h0D;
	localparam logic [7:0] TOK_CIRCLE_A  = 8'h51;
	localparam logic [7:0] TOK_CIRCLE_B  = 8'h54;
	localparam logic [7:0] TOK_CIRCLE_C  = 8'h55;
	localparam logic [7:0] TOK_TIME_A    = 8'h34;
	localparam logic [7:0] TOK_TIME_B    = 8'h35;
	localparam logic [7:0] TOK_POINT2D   = 8'h66;
	localparam logic [7:0] TOK_POINT3D_A = 8'h69;
	localparam logic [7:0] TOK_POINT3D_B = 8'h6A;
	localparam logic [7:0] TOK_VERSION   = 8'h36;
	localparam logic [7:0] TOK_SPEED_A   = 8'h70;
	localparam logic [7:0] TOK_SPEED_B   = 8'h6C;
	localparam logic [7:0] TOK_HEADING   = 8'h56;

	localparam int OPS_DEPTH  = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CONF_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR       = 2'd2;

	localparam logic [3:0]  RST_CONF_THRESHOLD = 4'd3;
	localparam logic [13:0] RST_MIN_YEAR       = 14'd2000;
	localparam logic [13:0] RST_MAX_YEAR       = 14'd2025;

	typedef struct packed {
		logic [3:0]  conf_threshold;
		logic [13:0] min_year;
		logic [13:0] max_year;
	} cfg_t;

	typedef struct packed {
		logic        report_valid;
		logic [7:0]  message_length;
		logic [3:0]  confidence;
		logic [39:0] timestamp;
		logic [31:0] latitude_raw;
		logic [31:0] longitude_raw;
		logic [15:0] radius;
		logic [7:0]  altitude;
		logic [15:0] speed_raw;
		logic        speed_valid;
		logic [8:0]  heading;
		logic        heading_valid;
	} report_t;

	// number of operand bytes that follow a token
	function automatic logic [3:0] operand_need(input logic [7:0] tok);
		logic [3:0] n;
		case (tok) inside
			TOK_LEN:                                   n = 4'd3;
			TOK_CIRCLE_A, TOK_CIRCLE_B, TOK_CIRCLE_C:  n = 4'd10;
			TOK_TIME_A, TOK_TIME_B:                    n = 4'd5;
			TOK_POINT2D:                               n = 4'd8;
			TOK_POINT3D_A, TOK_POINT3D_B:              n = 4'd9;
			TOK_VERSION, TOK_HEADING:                  n = 4'd1;
			TOK_SPEED_A, TOK_SPEED_B:                  n = 4'd2;
			default:                                   n = 4'd0;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

/* sv/lrrp_byte_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lrrp_byte_if
// Payload byte channel: one report byte per transaction with the addresses.
// ----------------------------------------------------------------------------
interface lrrp_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic [23:0] source_address;
	logic [23:0] dest_address;

	modport source (output valid, data_byte, last_byte, source_address, dest_address,
		input ready);
	modport sink (input valid, data_byte, last_byte, source_address, dest_address,
		output ready);
endinterface
`default_nettype wire

/* sv/lrrp_report_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lrrp_report_if
// Report channel: one decoded location report per transaction.
// ----------------------------------------------------------------------------
interface lrrp_report_if;
	logic        valid;
	logic        ready;
	logic        report_valid;
	logic [7:0]  message_length;
	logic [3:0]  confidence;
	logic [39:0] timestamp;
	logic [31:0] latitude_raw;
	logic [31:0] longitude_raw;
	logic [15:0] radius;
	logic [7:0]  altitude;
	logic [15:0] speed_raw;
	logic        speed_valid;
	logic [8:0]  heading;
	logic        heading_valid;

	modport source (output valid, report_valid, message_length, confidence, timestamp,
		latitude_raw, longitude_raw, radius, altitude, speed_raw, speed_valid, heading,
		heading_valid, input ready);
	modport sink (input valid, report_valid, message_length, confidence, timestamp,
		latitude_raw, longitude_raw, radius, altitude, speed_raw, speed_valid, heading,
		heading_valid, output ready);
endinterface
`default_nettype wire

/* sv/lrrp_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lrrp_cfg_regs
// Configuration registers: threshold and year window, written by index.
// ----------------------------------------------------------------------------
module lrrp_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [lrrp_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [lrrp_pkg::CFG_DATA_W-1:0]  wr_data,
	output lrrp_pkg::cfg_t                   cfg
);
	import lrrp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.conf_threshold <= RST_CONF_THRESHOLD;
			cfg_q.min_year       <= RST_MIN_YEAR;
			cfg_q.max_year       <= RST_MAX_YEAR;
		end else if (wr_en) begin
			case (wr_index)
				CFG_CONF_THRESHOLD: cfg_q.conf_threshold <= wr_data[3:0];
				CFG_MIN_YEAR:       cfg_q.min_year       <= wr_data[13:0];
				CFG_MAX_YEAR:       cfg_q.max_year       <= wr_data[13:0];
				default:            ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

/* sv/lrrp_parse_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lrrp_parse_core
// Input register, token state and operand decode for one byte per cycle unless a last byte stalls.
// ----------------------------------------------------------------------------
module lrrp_parse_core (
	input  logic              clk,
	input  logic              arst_n,
	lrrp_byte_if.sink         payload,
	input  lrrp_pkg::cfg_t    cfg,
	input  logic              res_room,
	output logic              res_valid,
	output lrrp_pkg::report_t res
);
	import lrrp_pkg::*;

	// input register
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic [23:0] src_s1;
	logic [23:0] dst_s1;
	logic        fire;

	// parser state
	logic        first_q;
	logic [3:0]  skip_q;
	logic [7:0]  pend_q;
	logic [7:0]  len_q;
	logic [3:0]  conf_q;
	logic [39:0] time_q;
	logic [31:0] lat_q;
	logic [31:0] lon_q;
	logic [15:0] rad_q;
	logic [7:0]  alt_q;
	logic [15:0] spd_q;
	logic        spd_seen_q;
	logic [8:0]  hdg_q;
	logic        hdg_seen_q;
	logic [7:0]  ops_q [OPS_DEPTH];

	logic [3:0]  skip_n;
	logic [7:0]  pend_n;
	logic [7:0]  len_n;
	logic [3:0]  conf_n;
	logic [39:0] time_n;
	logic [31:0] lat_n;
	logic [31:0] lon_n;
	logic [15:0] rad_n;
	logic [7:0]  alt_n;
	logic [15:0] spd_n;
	logic        spd_seen_n;
	logic [8:0]  hdg_n;
	logic        hdg_seen_n;

	logic        skipping;
	logic [3:0]  need;
	logic [3:0]  idx;
	logic [7:0]  ops [OPS_DEPTH];
	logic [31:0] word0;
	logic [31:0] word1;
	logic [13:0] yr;
	logic        add_src;
	logic        add_dst;
	logic        add_len;
	logic        add_dec;
	logic        tok_ok;
	logic [2:0]  inc;
	logic [4:0]  conf_sum;

	assign fire          = valid_s1 && (!last_s1 || res_room);
	assign payload.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (payload.ready) begin
			valid_s1 <= payload.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (payload.valid && payload.ready) begin
			data_s1 <= payload.data_byte;
			last_s1 <= payload.last_byte;
			src_s1  <= payload.source_address;
			dst_s1  <= payload.dest_address;
		end
	end

	assign skipping = skip_q != 4'd0;
	assign need     = operand_need(pend_q);
	assign idx      = (need >= skip_q) ? need - skip_q : 4'd0;

	// operand bytes as seen after this byte is stored
	always_comb begin
		for (int i = 0; i < OPS_DEPTH; i++) begin
			ops[i] = (skipping && idx == 4'(i)) ? data_s1 : ops_q[i];
		end
	end

	assign word0 = {ops[0], ops[1], ops[2], ops[3]};
	assign word1 = {ops[4], ops[5], ops[6], ops[7]};
	assign yr    = {ops[0], ops[1][7:2]};

	always_comb begin
		skip_n     = skip_q;
		pend_n     = pend_q;
		len_n      = len_q;
		time_n     = time_q;
		lat_n      = lat_q;
		lon_n      = lon_q;
		rad_n      = rad_q;
		alt_n      = alt_q;
		spd_n      = spd_q;
		spd_seen_n = spd_seen_q;
		hdg_n      = hdg_q;
		hdg_seen_n = hdg_seen_q;
		add_src    = first_q && (src_s1 != 24'd0);
		add_dst    = first_q && (dst_s1 != 24'd0);
		add_len    = 1'b0;
		add_dec    = 1'b0;
		tok_ok     = 1'b0;

		if (skipping) begin
			if (pend_q == TOK_LEN && idx == 4'd0) begin
				len_n   = data_s1;
				add_len = 1'b1;
			end
			skip_n = skip_q - 4'd1;
			if (skip_q == 4'd1) begin
				pend_n = 8'd0;
				case (pend_q) inside
					TOK_CIRCLE_A, TOK_CIRCLE_B, TOK_CIRCLE_C,
					TOK_POINT3D_A, TOK_POINT3D_B: begin
						lat_n = word0;
						lon_n = word1;
						if (pend_q == TOK_POINT3D_A || pend_q == TOK_POINT3D_B) begin
							alt_n = ops[8];
						end else begin
							rad_n = {ops[8], ops[9]};
						end
						if (word0 != 32'd0 && word1 != 32'd0) begin
							add_dec = 1'b1;
						end else begin
							lat_n = 32'd0;
						end
					end
					TOK_POINT2D: begin
						lat_n   = word0;
						lon_n   = word1;
						add_dec = 1'b1;
					end
					TOK_TIME_A, TOK_TIME_B: begin
						add_dec = (yr > cfg.min_year) &&
							({1'b0, yr} <= {1'b0, cfg.max_year} + 15'd1);
						if (yr > cfg.max_year || yr < cfg.min_year) begin
							time_n = 40'd0;
						end else begin
							time_n = {yr, ops[1][1:0], ops[2][7:6], ops[2][5:1],
								ops[2][0], ops[3][7:4], ops[3][3:0], ops[4][7:6],
								ops[4][5:0]};
						end
					end
					TOK_SPEED_A, TOK_SPEED_B: begin
						spd_n      = {ops[0], ops[1]};
						spd_seen_n = 1'b1;
						add_dec    = 1'b1;
					end
					TOK_HEADING: begin
						hdg_n      = {ops[0], 1'b0};
						hdg_seen_n = 1'b1;
						add_dec    = 1'b1;
					end
					default: ;
				endcase
			end
		end else begin
			case (data_s1) inside
				TOK_LEN: tok_ok = first_q;
				TOK_CIRCLE_A, TOK_CIRCLE_B, TOK_CIRCLE_C,
				TOK_POINT2D, TOK_POINT3D_A, TOK_POINT3D_B:
					tok_ok = (len_q != 8'd0) && (lat_q == 32'd0);
				TOK_TIME_A, TOK_TIME_B:
					tok_ok = (len_q != 8'd0) && (time_q[39:26] == 14'd0);
				TOK_VERSION: tok_ok = 1'b1;
				TOK_SPEED_A, TOK_SPEED_B: tok_ok = (len_q != 8'd0) && !spd_seen_q;
				TOK_HEADING: tok_ok = (len_q != 8'd0) && !hdg_seen_q;
				default: tok_ok = 1'b0;
			endcase
			if (tok_ok) begin
				pend_n = data_s1;
				skip_n = operand_need(data_s1);
			end
		end

		inc      = {2'b00, add_src} + {2'b00, add_dst} + {2'b00, add_len} + {2'b00, add_dec};
		conf_sum = {1'b0, conf_q} + {2'b00, inc};
		conf_n   = (conf_sum > 5'd15) ? 4'hF : conf_sum[3:0];
	end

	always_comb begin
		res.report_valid   = (len_n != 8'd0) && (conf_n >= cfg.conf_threshold);
		res.message_length = len_n;
		res.confidence     = conf_n;
		res.timestamp      = time_n;
		res.latitude_raw   = lat_n;
		res.longitude_raw  = lon_n;
		res.radius         = rad_n;
		res.altitude       = alt_n;
		res.speed_raw      = spd_n;
		res.speed_valid    = spd_seen_n;
		res.heading        = hdg_n;
		res.heading_valid  = hdg_seen_n;
	end

	assign res_valid = fire && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q    <= 1'b1;
			skip_q     <= 4'd0;
			pend_q     <= 8'd0;
			len_q      <= 8'd0;
			conf_q     <= 4'd0;
			time_q     <= 40'd0;
			lat_q      <= 32'd0;
			lon_q      <= 32'd0;
			rad_q      <= 16'd0;
			alt_q      <= 8'd0;
			spd_q      <= 16'd0;
			spd_seen_q <= 1'b0;
			hdg_q      <= 9'd0;
			hdg_seen_q <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				// report goes out, start over for the next one
				first_q    <= 1'b1;
				skip_q     <= 4'd0;
				pend_q     <= 8'd0;
				len_q      <= 8'd0;
				conf_q     <= 4'd0;
				time_q     <= 40'd0;
				lat_q      <= 32'd0;
				lon_q      <= 32'd0;
				rad_q      <= 16'd0;
				alt_q      <= 8'd0;
				spd_q      <= 16'd0;
				spd_seen_q <= 1'b0;
				hdg_q      <= 9'd0;
				hdg_seen_q <= 1'b0;
			end else begin
				first_q    <= 1'b0;
				skip_q     <= skip_n;
				pend_q     <= pend_n;
				len_q      <= len_n;
				conf_q     <= conf_n;
				time_q     <= time_n;
				lat_q      <= lat_n;
				lon_q      <= lon_n;
				rad_q      <= rad_n;
				alt_q      <= alt_n;
				spd_q      <= spd_n;
				spd_seen_q <= spd_seen_n;
				hdg_q      <= hdg_n;
				hdg_seen_q <= hdg_seen_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < OPS_DEPTH; i++) begin
			if (fire && skipping && idx == 4'(i)) begin
				ops_q[i] <= data_s1;
			end
		end
	end
endmodule
`default_nettype wire

/* sv/lrrp_out_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lrrp_out_reg
// Result register: holds one finished report until the sink takes it.
// ----------------------------------------------------------------------------
module lrrp_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  lrrp_pkg::report_t res,
	output logic              res_room,
	lrrp_report_if.source     report
);
	import lrrp_pkg::*;

	logic    valid_q;
	report_t data_q;

	assign res_room = !valid_q || report.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid) begin
			valid_q <= 1'b1;
		end else if (report.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			data_q <= res;
		end
	end

	assign report.valid          = valid_q;
	assign report.report_valid   = data_q.report_valid;
	assign report.message_length = data_q.message_length;
	assign report.confidence     = data_q.confidence;
	assign report.timestamp      = data_q.timestamp;
	assign report.latitude_raw   = data_q.latitude_raw;
	assign report.longitude_raw  = data_q.longitude_raw;
	assign report.radius         = data_q.radius;
	assign report.altitude       = data_q.altitude;
	assign report.speed_raw      = data_q.speed_raw;
	assign report.speed_valid    = data_q.speed_valid;
	assign report.heading        = data_q.heading;
	assign report.heading_valid  = data_q.heading_valid;
endmodule
`default_nettype wire

/* sv/lrrp_location_token_parser_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lrrp_location_token_parser_top
// Location report token parser: one payload byte in, one report per message.
// ----------------------------------------------------------------------------
// The block takes one payload byte per cycle, sustained except while a last
// byte stalls. A byte passes an input register, then updates the token state
// and operand decode; the byte flagged last loads the result register, which
// offers the report until the sink takes it. The result register holds one
// report, and bytes that are not last keep flowing while it waits; only a
// last byte stalls, and then only while the previous report is still untaken.
// Configuration registers are written through cfg_wr_en / cfg_index / cfg_data.
module lrrp_location_token_parser_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [lrrp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lrrp_pkg::CFG_DATA_W-1:0]  cfg_data,
	lrrp_byte_if.sink                        payload,
	lrrp_report_if.source                    report
);
	import lrrp_pkg::*;

	cfg_t    cfg;
	logic    res_valid;
	logic    res_room;
	report_t res;

	lrrp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lrrp_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.payload   (payload),
		.cfg       (cfg),
		.res_room  (res_room),
		.res_valid (res_valid),
		.res       (res)
	);

	lrrp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_room  (res_room),
		.report    (report)
	);

	// a new report never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!report.valid || report.ready))
		else $error("report overwritten while waiting");

	assert property (@(posedge clk) disable iff (!arst_n)
		(report.valid && report.report_valid) |-> (report.message_length != 8'd0))
		else $error("valid report without length");

	assert property (@(posedge clk) disable iff (!arst_n)
		report.valid |-> (report.heading[0] == 1'b0))
		else $error("odd heading");

	assert property (@(posedge clk) disable iff (!arst_n)
		(report.valid && !report.speed_valid) |-> (report.speed_raw == 16'd0))
		else $error("speed value without speed token");
endmodule
`default_nettype wire
